// ===== design/rounded_rect_clip_test_core_assert.svh =====
// Assertion macros for the rounded rectangle clip test core.
`ifndef ROUNDED_RECT_CLIP_TEST_CORE_ASSERT_SVH
`define ROUNDED_RECT_CLIP_TEST_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RRCT_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rrct assertion failed");
`define RRCT_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rrct assertion failed");
`else
`define RRCT_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define RRCT_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ===== design/rrct_pkg.sv =====
// Shared constants, types and register codes for the rounded rectangle clip test.
package rrct_pkg;

	localparam int COORD_BITS  = 16;
	localparam int FRAC_BITS   = 4;
	localparam int SIZE_BITS   = COORD_BITS - 1;
	localparam int RADIUS_BITS = COORD_BITS + FRAC_BITS;
	localparam int RAD_W       = RADIUS_BITS - 1;
	localparam int C_W         = RAD_W + 1;
	localparam int RR_W        = 2 * C_W;
	localparam int SUM_W       = RAD_W + 1;
	localparam int SCALE_W     = 17;
	localparam int QUOT_W      = SCALE_W - 1;
	localparam int DIV_STEPS   = QUOT_W;
	localparam int CNT_W       = $clog2(DIV_STEPS + 2);
	localparam int GEO_W       = COORD_BITS + FRAC_BITS + 4;

	localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << QUOT_W;

	localparam int N_CORNERS = 4;
	localparam int CORNER_W  = 2;
	localparam logic [CORNER_W-1:0] CORNER_TL   = CORNER_W'(0);
	localparam logic [CORNER_W-1:0] CORNER_TR   = CORNER_W'(1);
	localparam logic [CORNER_W-1:0] CORNER_BR   = CORNER_W'(2);
	localparam logic [CORNER_W-1:0] CORNER_BL   = CORNER_W'(3);
	localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(N_CORNERS - 1);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam int APB_DW    = 32;
	localparam int REG_IDX_W = 3;
	localparam int PADDR_W   = REG_IDX_W + 2;

	localparam logic [REG_IDX_W-1:0] REG_RECT_LEFT   = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_RECT_TOP    = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_RECT_WIDTH  = REG_IDX_W'(2);
	localparam logic [REG_IDX_W-1:0] REG_RECT_HEIGHT = REG_IDX_W'(3);
	localparam logic [REG_IDX_W-1:0] REG_RAD_TL      = REG_IDX_W'(4);
	localparam logic [REG_IDX_W-1:0] REG_RAD_TR      = REG_IDX_W'(5);
	localparam logic [REG_IDX_W-1:0] REG_RAD_BR      = REG_IDX_W'(6);
	localparam logic [REG_IDX_W-1:0] REG_RAD_BL      = REG_IDX_W'(7);

	typedef logic signed [GEO_W-1:0] geo_coord_t;

	localparam geo_coord_t GEO_HALF = geo_coord_t'(1) << FRAC_BITS;

	typedef struct packed {
		geo_coord_t lq;
		geo_coord_t rq;
		geo_coord_t tq;
		geo_coord_t bq;
		geo_coord_t c0x;
		geo_coord_t c0y;
		geo_coord_t c1x;
		geo_coord_t c1y;
		geo_coord_t c2x;
		geo_coord_t c2y;
		geo_coord_t c3x;
		geo_coord_t c3y;
	} geo_t;

	typedef logic [N_CORNERS-1:0][RR_W-1:0]  rr_arr_t;
	typedef logic [N_CORNERS-1:0][RAD_W-1:0] rad_arr_t;

	typedef enum logic [1:0] {
		KIND_OUTSIDE,
		KIND_INSIDE,
		KIND_ARC
	} item_kind_t;

	typedef struct packed {
		item_kind_t          kind;
		logic [CORNER_W-1:0] corner;
		logic [C_W-1:0]      dx;
		logic [C_W-1:0]      dy;
	} fifo_entry_t;

	typedef enum logic [2:0] {
		PS_IDLE,
		PS_DIV,
		PS_MUL,
		PS_SQ,
		PS_GEO
	} prep_state_t;

endpackage

// ===== design/rrct_prep.sv =====
// Register file and setup sequencer: radius clamp, edge ratio divide, scaling, squares, corner geometry.
module rrct_prep import rrct_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0]  pwdata,
	output logic [APB_DW-1:0]  prdata,
	output logic               busy,
	output geo_t               geo,
	output rr_arr_t            rr
);

	logic [COORD_BITS-1:0]  left_q;
	logic [COORD_BITS-1:0]  top_q;
	logic [SIZE_BITS-1:0]   width_q;
	logic [SIZE_BITS-1:0]   height_q;
	logic [RADIUS_BITS-1:0] rad_tl_q;
	logic [RADIUS_BITS-1:0] rad_tr_q;
	logic [RADIUS_BITS-1:0] rad_br_q;
	logic [RADIUS_BITS-1:0] rad_bl_q;

	prep_state_t          state_q, state_n;
	logic [CORNER_W-1:0]  edge_q;
	logic [CORNER_W-1:0]  idx_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [SUM_W-1:0]     rem_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 take_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [SCALE_W-1:0]   scale_q;
	rad_arr_t             rs_q;
	rr_arr_t              rr_q;
	geo_t                 geo_q;

	logic                 wr_en;
	logic [REG_IDX_W-1:0] reg_idx;
	rad_arr_t             rc;
	logic [RAD_W-1:0]     ea, eb;
	logic [SIZE_BITS-1:0] elen;
	logic [SUM_W-1:0]     sum_sel, eq_sel;
	logic [SUM_W:0]       rem2, rem_sub;
	logic                 div_ge;
	logic [RAD_W+SCALE_W-1:0] mul_prod;
	logic [2*RAD_W-1:0]   sq_prod;
	logic                 div_last;
	geo_t                 geo_n;

	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= '0;
			height_q <= '0;
			rad_tl_q <= '0;
			rad_tr_q <= '0;
			rad_br_q <= '0;
			rad_bl_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_RECT_LEFT:   left_q   <= pwdata[COORD_BITS-1:0];
				REG_RECT_TOP:    top_q    <= pwdata[COORD_BITS-1:0];
				REG_RECT_WIDTH:  width_q  <= pwdata[SIZE_BITS-1:0];
				REG_RECT_HEIGHT: height_q <= pwdata[SIZE_BITS-1:0];
				REG_RAD_TL:      rad_tl_q <= pwdata[RADIUS_BITS-1:0];
				REG_RAD_TR:      rad_tr_q <= pwdata[RADIUS_BITS-1:0];
				REG_RAD_BR:      rad_br_q <= pwdata[RADIUS_BITS-1:0];
				REG_RAD_BL:      rad_bl_q <= pwdata[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_RECT_LEFT:   prdata = APB_DW'(left_q);
			REG_RECT_TOP:    prdata = APB_DW'(top_q);
			REG_RECT_WIDTH:  prdata = APB_DW'(width_q);
			REG_RECT_HEIGHT: prdata = APB_DW'(height_q);
			REG_RAD_TL:      prdata = APB_DW'(rad_tl_q);
			REG_RAD_TR:      prdata = APB_DW'(rad_tr_q);
			REG_RAD_BR:      prdata = APB_DW'(rad_br_q);
			REG_RAD_BL:      prdata = APB_DW'(rad_bl_q);
			default:         prdata = '0;
		endcase
	end

	// negative radii clamp to zero
	assign rc[0] = rad_tl_q[RADIUS_BITS-1] ? '0 : rad_tl_q[RAD_W-1:0];
	assign rc[1] = rad_tr_q[RADIUS_BITS-1] ? '0 : rad_tr_q[RAD_W-1:0];
	assign rc[2] = rad_br_q[RADIUS_BITS-1] ? '0 : rad_br_q[RAD_W-1:0];
	assign rc[3] = rad_bl_q[RADIUS_BITS-1] ? '0 : rad_bl_q[RAD_W-1:0];

	always_comb begin
		case (edge_q)
			CORNER_TL: begin
				ea = rc[0]; eb = rc[1]; elen = width_q;
			end
			CORNER_TR: begin
				ea = rc[1]; eb = rc[2]; elen = height_q;
			end
			CORNER_BR: begin
				ea = rc[2]; eb = rc[3]; elen = width_q;
			end
			default: begin
				ea = rc[3]; eb = rc[0]; elen = height_q;
			end
		endcase
	end

	assign sum_sel  = SUM_W'(ea) + SUM_W'(eb);
	assign eq_sel   = SUM_W'(elen) << FRAC_BITS;
	assign rem2     = {rem_q, 1'b0};
	assign div_ge   = rem2 >= {1'b0, sum_q};
	assign rem_sub  = rem2 - {1'b0, sum_q};
	assign div_last = cnt_q == CNT_W'(DIV_STEPS + 1);
	assign mul_prod = (RAD_W+SCALE_W)'(rc[idx_q]) * (RAD_W+SCALE_W)'(scale_q);
	assign sq_prod  = (2*RAD_W)'(rs_q[idx_q]) * (2*RAD_W)'(rs_q[idx_q]);

	always_comb begin
		logic signed [COORD_BITS:0] right_s, bottom_s;
		geo_coord_t c0, c1, c2, c3;
		right_s   = $signed({left_q[COORD_BITS-1], left_q}) + $signed({2'b00, width_q});
		bottom_s  = $signed({top_q[COORD_BITS-1], top_q}) + $signed({2'b00, height_q});
		c0        = geo_coord_t'({rs_q[0], 1'b0});
		c1        = geo_coord_t'({rs_q[1], 1'b0});
		c2        = geo_coord_t'({rs_q[2], 1'b0});
		c3        = geo_coord_t'({rs_q[3], 1'b0});
		geo_n.lq  = geo_coord_t'($signed(left_q)) <<< (FRAC_BITS + 1);
		geo_n.tq  = geo_coord_t'($signed(top_q)) <<< (FRAC_BITS + 1);
		geo_n.rq  = geo_coord_t'(right_s) <<< (FRAC_BITS + 1);
		geo_n.bq  = geo_coord_t'(bottom_s) <<< (FRAC_BITS + 1);
		geo_n.c0x = geo_n.lq + c0;
		geo_n.c0y = geo_n.tq + c0;
		geo_n.c1x = geo_n.rq - c1;
		geo_n.c1y = geo_n.tq + c1;
		geo_n.c2x = geo_n.rq - c2;
		geo_n.c2y = geo_n.bq - c2;
		geo_n.c3x = geo_n.lq + c3;
		geo_n.c3y = geo_n.bq - c3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			PS_IDLE: state_n = PS_IDLE;
			PS_DIV: begin
				if (div_last && edge_q == LAST_CORNER)
					state_n = PS_MUL;
			end
			PS_MUL: begin
				if (idx_q == LAST_CORNER)
					state_n = PS_SQ;
			end
			PS_SQ: begin
				if (idx_q == LAST_CORNER)
					state_n = PS_GEO;
			end
			PS_GEO:  state_n = PS_IDLE;
			default: state_n = PS_IDLE;
		endcase
		if (wr_en)
			state_n = PS_DIV;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_q  <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			scale_q <= SCALE_ONE;
			rs_q    <= '0;
			rr_q    <= '0;
			geo_q   <= '0;
		end else if (wr_en) begin
			edge_q  <= '0;
			idx_q   <= '0;
			cnt_q   <= '0;
			scale_q <= SCALE_ONE;
		end else begin
			case (state_q)
				PS_DIV: begin
					if (div_last) begin
						cnt_q  <= '0;
						edge_q <= edge_q + CORNER_W'(1);
						if (take_q && SCALE_W'(quot_q) < scale_q)
							scale_q <= SCALE_W'(quot_q);
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				PS_MUL: begin
					rs_q[idx_q] <= mul_prod[QUOT_W +: RAD_W];
					idx_q       <= idx_q + CORNER_W'(1);
				end
				PS_SQ: begin
					rr_q[idx_q] <= {sq_prod, 2'b00};
					idx_q       <= idx_q + CORNER_W'(1);
				end
				PS_GEO:  geo_q <= geo_n;
				default: ;
			endcase
		end
	end

	// restoring divide of (edge << 4) by the radius sum, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == PS_DIV) begin
			if (cnt_q == '0) begin
				rem_q  <= eq_sel;
				sum_q  <= sum_sel;
				take_q <= sum_sel > eq_sel;
				quot_q <= '0;
			end else if (!div_last) begin
				if (div_ge) begin
					rem_q  <= rem_sub[SUM_W-1:0];
					quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem2[SUM_W-1:0];
					quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
				end
			end
		end
	end

	assign busy = state_q != PS_IDLE;
	assign geo  = geo_q;
	assign rr   = rr_q;

endmodule

// ===== design/rrct_front.sv =====
// Front end: pixel centre, rectangle bounds and corner quadrant classification.
module rrct_front import rrct_pkg::*; (
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	input  geo_t                  geo,
	output fifo_entry_t           item
);

	geo_coord_t px, py;
	geo_coord_t lq, rq, tq, bq;
	geo_coord_t c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
	logic       in_rect;

	function automatic logic [C_W-1:0] absdiff(input geo_coord_t a, input geo_coord_t b);
		geo_coord_t d;
		d = a - b;
		if (d[GEO_W-1])
			d = -d;
		return d[C_W-1:0];
	endfunction

	assign lq  = geo.lq;
	assign rq  = geo.rq;
	assign tq  = geo.tq;
	assign bq  = geo.bq;
	assign c0x = geo.c0x;
	assign c0y = geo.c0y;
	assign c1x = geo.c1x;
	assign c1y = geo.c1y;
	assign c2x = geo.c2x;
	assign c2y = geo.c2y;
	assign c3x = geo.c3x;
	assign c3y = geo.c3y;

	assign px = (geo_coord_t'($signed(point_x)) <<< (FRAC_BITS + 1)) + GEO_HALF;
	assign py = (geo_coord_t'($signed(point_y)) <<< (FRAC_BITS + 1)) + GEO_HALF;

	// centres sit on odd half-pixel steps, so an empty rectangle never passes
	assign in_rect = (px > lq) && (px < rq) && (py > tq) && (py < bq);

	always_comb begin
		item.kind   = KIND_INSIDE;
		item.corner = CORNER_TL;
		item.dx     = '0;
		item.dy     = '0;
		if (!in_rect) begin
			item.kind = KIND_OUTSIDE;
		end else if (px < c0x && py < c0y) begin
			item.kind   = KIND_ARC;
			item.corner = CORNER_TL;
			item.dx     = absdiff(px, c0x);
			item.dy     = absdiff(py, c0y);
		end else if (px > c1x && py < c1y) begin
			item.kind   = KIND_ARC;
			item.corner = CORNER_TR;
			item.dx     = absdiff(px, c1x);
			item.dy     = absdiff(py, c1y);
		end else if (px > c2x && py > c2y) begin
			item.kind   = KIND_ARC;
			item.corner = CORNER_BR;
			item.dx     = absdiff(px, c2x);
			item.dy     = absdiff(py, c2y);
		end else if (px < c3x && py > c3y) begin
			item.kind   = KIND_ARC;
			item.corner = CORNER_BL;
			item.dx     = absdiff(px, c3x);
			item.dy     = absdiff(py, c3y);
		end
	end

endmodule

// ===== design/rrct_fifo.sv =====
// Short queue of classified items between front and back.
module rrct_fifo import rrct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  fifo_entry_t wdata,
	input  logic        pop,
	output fifo_entry_t rdata,
	output logic        empty,
	output logic        full
);

	fifo_entry_t        mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + FIFO_CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - FIFO_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	assign rdata = mem_q[rd_ptr_q];
	assign empty = cnt_q == '0;
	assign full  = cnt_q == FIFO_CW'(FIFO_DEPTH);

endmodule

// ===== design/rrct_back.sv =====
// Back end: squared distances, radius compare and output register.
module rrct_back import rrct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fifo_entry_t head,
	input  logic        empty,
	output logic        pop,
	input  rr_arr_t     rr,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        inside_res,
	output logic        b1_valid
);

	logic                b1_valid_s1;
	item_kind_t          kind_s1;
	logic [CORNER_W-1:0] corner_s1;
	logic [RR_W-1:0]     dxx_s1, dyy_s1;
	logic                out_valid_q, inside_q;
	logic                out_free, b1_adv;
	logic [RR_W:0]       dist2;
	logic                arc_in, inside_n;

	assign out_free = !out_valid_q || !out_stall;
	assign b1_adv   = !b1_valid_s1 || out_free;
	assign pop      = !empty && b1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (b1_adv)
				b1_valid_s1 <= pop;
			if (out_free)
				out_valid_q <= b1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1   <= head.kind;
			corner_s1 <= head.corner;
			dxx_s1    <= RR_W'(head.dx) * RR_W'(head.dx);
			dyy_s1    <= RR_W'(head.dy) * RR_W'(head.dy);
		end
	end

	assign dist2  = {1'b0, dxx_s1} + {1'b0, dyy_s1};
	assign arc_in = dist2 <= {1'b0, rr[corner_s1]};

	always_comb begin
		case (kind_s1)
			KIND_INSIDE: inside_n = 1'b1;
			KIND_ARC:    inside_n = arc_in;
			default:     inside_n = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_free && b1_valid_s1)
			inside_q <= inside_n;
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_q;
	assign b1_valid   = b1_valid_s1;

endmodule

// ===== design/rounded_rect_clip_test_core.sv =====
// Accept to out_valid through an empty queue: queue entry, square stage, output register;
// one transaction per cycle, both back-end stages fed, while in_stall and out_stall are low.
// Any register write restarts setup (edge ratio divide, scaling, squares, geometry):
// in_stall stays high throughout, so the next transaction is taken only after it ends.
// arst_n clears registers and derived geometry to zero, empties the queue; no clearing pass.
`include "rounded_rect_clip_test_core_assert.svh"
module rounded_rect_clip_test_core import rrct_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DW-1:0]     pwdata,
	output logic [APB_DW-1:0]     prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] point_x,
	input  logic [COORD_BITS-1:0] point_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  inside_res
);

	logic        busy;
	geo_t        geo;
	rr_arr_t     rr;
	fifo_entry_t item, head;
	logic        q_empty, q_full, q_pop, in_acc, b1_valid;

	assign pready   = 1'b1;
	assign in_stall = busy || q_full;
	assign in_acc   = in_valid && !in_stall;

	rrct_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.busy    (busy),
		.geo     (geo),
		.rr      (rr)
	);

	rrct_front u_front (
		.point_x (point_x),
		.point_y (point_y),
		.geo     (geo),
		.item    (item)
	);

	rrct_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_acc),
		.wdata  (item),
		.pop    (q_pop),
		.rdata  (head),
		.empty  (q_empty),
		.full   (q_full)
	);

	rrct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.empty      (q_empty),
		.pop        (q_pop),
		.rr         (rr),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res),
		.b1_valid   (b1_valid)
	);

	`RRCT_ASSERT_NXT(a_cfg_stalls, clk, arst_n, psel && penable && pwrite, in_stall)
	`RRCT_ASSERT_NXT(a_push_lands, clk, arst_n, in_valid && !in_stall, !q_empty)
	`RRCT_ASSERT_IMP(a_out_from_b1, clk, arst_n, $rose(out_valid), $past(b1_valid))

endmodule
